@@ rtl/core/bcc_pkg.sv @@
package bcc_pkg;

    // Configuration port geometry: seven registers, read and written as 32-bit words at word addresses.
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = 3;

    // Register indexes, in the order of the register map.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_DEBOUNCE_TIME   = 3'd0,
        REG_LONG_PRESS_TIME = 3'd1,
        REG_DOUBLE_WINDOW   = 3'd2,
        REG_SHORT_ACTION    = 3'd3,
        REG_DOUBLE_ACTION   = 3'd4,
        REG_LONG_ACTION     = 3'd5,
        REG_ENABLE_MASK     = 3'd6
    } t_reg_idx;

    // Field widths of the sample and event transfers, the registers and the click counter.
    localparam int unsigned BTN_W    = 3;
    localparam int unsigned NOW_W    = 32;
    localparam int unsigned MS_CFG_W = 16;
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned MASK_W   = 8;
    localparam int unsigned CLICK_W  = 2;

    // Click counter limits.
    localparam logic [CLICK_W-1:0] CLICK_MAX     = 2'd3;
    localparam logic [CLICK_W-1:0] DOUBLE_CLICKS = 2'd2;

    // Register reset values.
    localparam logic [MS_CFG_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [MS_CFG_W-1:0] LONG_RST     = 16'd800;
    localparam logic [MS_CFG_W-1:0] WINDOW_RST   = 16'd300;

endpackage

@@ rtl/core/bcc_if.sv @@
// Poll sample channel: one button level with its timestamp.
interface bcc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  button_index;
    logic        raw_level;
    logic [31:0] now_ms;

    modport source (output valid, output button_index, output raw_level, output now_ms,
                    input ready);
    modport sink   (input valid, input button_index, input raw_level, input now_ms,
                    output ready);
endinterface

// Event channel: one action code for one button.
interface bcc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_button;
    logic [7:0] action_code;

    modport source (output valid, output event_button, output action_code, input ready);
    modport sink   (input valid, input event_button, input action_code, output ready);
endinterface

@@ rtl/core/button_click_classifier_unit.sv @@
// A sample transfer loads the input register; its event loads into the event register when
// that is free. Throughput: one sample per cycle while no event stalls; the input register
// feeds one pass of compare logic against the addressed button's state, written back with
// the event register. A stalled event holds the sample behind it, so the input takes one
// more sample and then stalls. Reset (synchronous, active low) clears all button state to
// released with no clicks, and loads the register defaults; there is no clearing pass.
module button_click_classifier_unit
    import bcc_pkg::*;
#(
    parameter int NUM_BUTTONS = 8,
    parameter int TIME_BITS   = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bcc_in_if.sink                i_in,
    bcc_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // Configuration registers.
    logic [MS_CFG_W-1:0] r_debounce;
    logic [MS_CFG_W-1:0] r_long_time;
    logic [MS_CFG_W-1:0] r_window;
    logic [CODE_W-1:0]   r_short_code;
    logic [CODE_W-1:0]   r_double_code;
    logic [CODE_W-1:0]   r_long_code;
    logic [MASK_W-1:0]   r_enable;

    // Input register.
    logic             r_in_vld;
    logic [BTN_W-1:0] r_in_btn;
    logic             r_in_raw;
    logic [NOW_W-1:0] r_in_now;

    // Event register.
    logic              r_out_vld;
    logic [BTN_W-1:0]  r_out_btn;
    logic [CODE_W-1:0] r_out_code;

    // Per-button state.
    logic                 r_last_raw   [NUM_BUTTONS];
    logic                 r_stable     [NUM_BUTTONS];
    logic                 r_long_fired [NUM_BUTTONS];
    logic [CLICK_W-1:0]   r_clicks     [NUM_BUTTONS];
    logic [TIME_BITS-1:0] r_raw_time   [NUM_BUTTONS];
    logic [TIME_BITS-1:0] r_press_time [NUM_BUTTONS];
    logic [TIME_BITS-1:0] r_rel_time   [NUM_BUTTONS];

    logic                 w_cfg_wr;
    t_reg_idx             w_reg_idx;
    logic                 w_out_free;
    logic [IDX_W-1:0]     w_idx;
    logic                 w_active;
    logic [TIME_BITS-1:0] w_now;
    logic                 w_raw_chg;
    logic [TIME_BITS-1:0] n_raw_time;
    logic                 w_stab_chg;
    logic                 n_stable;
    logic [TIME_BITS-1:0] n_press_time;
    logic [TIME_BITS-1:0] n_rel_time;
    logic                 w_long_mid;
    logic [CLICK_W-1:0]   w_clicks_mid;
    logic                 w_long_hit;
    logic                 w_click_hit;
    logic                 n_long_fired;
    logic [CLICK_W-1:0]   n_clicks;
    logic [CODE_W-1:0]    w_action;
    logic                 w_emit;

    // Configuration port: zero-wait writes, registers readable at their addresses.
    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce    <= DEBOUNCE_RST;
            r_long_time   <= LONG_RST;
            r_window      <= WINDOW_RST;
            r_short_code  <= '0;
            r_double_code <= '0;
            r_long_code   <= '0;
            r_enable      <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_DEBOUNCE_TIME:   r_debounce    <= pwdata[MS_CFG_W-1:0];
                REG_LONG_PRESS_TIME: r_long_time   <= pwdata[MS_CFG_W-1:0];
                REG_DOUBLE_WINDOW:   r_window      <= pwdata[MS_CFG_W-1:0];
                REG_SHORT_ACTION:    r_short_code  <= pwdata[CODE_W-1:0];
                REG_DOUBLE_ACTION:   r_double_code <= pwdata[CODE_W-1:0];
                REG_LONG_ACTION:     r_long_code   <= pwdata[CODE_W-1:0];
                REG_ENABLE_MASK:     r_enable      <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_DEBOUNCE_TIME:   prdata = APB_DATA_W'(r_debounce);
            REG_LONG_PRESS_TIME: prdata = APB_DATA_W'(r_long_time);
            REG_DOUBLE_WINDOW:   prdata = APB_DATA_W'(r_window);
            REG_SHORT_ACTION:    prdata = APB_DATA_W'(r_short_code);
            REG_DOUBLE_ACTION:   prdata = APB_DATA_W'(r_double_code);
            REG_LONG_ACTION:     prdata = APB_DATA_W'(r_long_code);
            REG_ENABLE_MASK:     prdata = APB_DATA_W'(r_enable);
            default:             prdata = '0;
        endcase
    end

    // Handshake: the input register moves on whenever it is empty or the event register can load.
    assign w_out_free = !r_out_vld || o_out.ready;
    assign i_in.ready = !r_in_vld || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_btn <= i_in.button_index;
            r_in_raw <= i_in.raw_level;
            r_in_now <= i_in.now_ms;
        end
    end

    // Select the addressed button; out-of-range and disabled buttons are ignored.
    assign w_idx    = IDX_W'(r_in_btn);
    assign w_now    = TIME_BITS'(r_in_now);
    assign w_active = r_in_vld && (32'(r_in_btn) < NUM_BUTTONS) && r_enable[r_in_btn];

    // Debounce, click counting and action selection for one sample.
    always_comb begin
        w_raw_chg  = (r_in_raw != r_last_raw[w_idx]);
        n_raw_time = w_raw_chg ? w_now : r_raw_time[w_idx];
        w_stab_chg = (r_stable[w_idx] != r_in_raw)
                     && ((w_now - n_raw_time) >= TIME_BITS'(r_debounce));
        n_stable   = w_stab_chg ? r_in_raw : r_stable[w_idx];

        n_press_time = r_press_time[w_idx];
        n_rel_time   = r_rel_time[w_idx];
        w_long_mid   = r_long_fired[w_idx];
        w_clicks_mid = r_clicks[w_idx];
        if (w_stab_chg) begin
            if (r_in_raw) begin
                n_press_time = w_now;
                w_long_mid   = 1'b0;
            end else if (!r_long_fired[w_idx]) begin
                if (w_clicks_mid != CLICK_MAX) begin
                    w_clicks_mid = w_clicks_mid + CLICK_W'(1);
                end
                n_rel_time = w_now;
            end
        end

        w_long_hit  = n_stable && !w_long_mid
                      && ((w_now - n_press_time) >= TIME_BITS'(r_long_time));
        w_click_hit = !n_stable && (w_clicks_mid != '0)
                      && ((w_now - n_rel_time) >= TIME_BITS'(r_window));

        n_long_fired = w_long_mid;
        n_clicks     = w_clicks_mid;
        w_action     = '0;
        if (w_long_hit) begin
            n_long_fired = 1'b1;
            n_clicks     = '0;
            w_action     = r_long_code;
        end else if (w_click_hit) begin
            n_clicks = '0;
            w_action = (w_clicks_mid >= DOUBLE_CLICKS) ? r_double_code : r_short_code;
        end

        w_emit = w_active && (w_action != '0);
    end

    // State write-back for the processed button.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_last_raw[i]   <= 1'b0;
                r_stable[i]     <= 1'b0;
                r_long_fired[i] <= 1'b0;
                r_clicks[i]     <= '0;
                r_raw_time[i]   <= '0;
                r_press_time[i] <= '0;
                r_rel_time[i]   <= '0;
            end
        end else if (w_active && w_out_free) begin
            r_last_raw[w_idx]   <= r_in_raw;
            r_stable[w_idx]     <= n_stable;
            r_long_fired[w_idx] <= n_long_fired;
            r_clicks[w_idx]     <= n_clicks;
            r_raw_time[w_idx]   <= n_raw_time;
            r_press_time[w_idx] <= n_press_time;
            r_rel_time[w_idx]   <= n_rel_time;
        end
    end

    // Event register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_emit) begin
            r_out_btn  <= r_in_btn;
            r_out_code <= w_action;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.event_button = r_out_btn;
    assign o_out.action_code  = r_out_code;

endmodule

@@ dv/click_event_checker.sv @@
`timescale 1ns / 100ps

// Watches the sample, event and register channels of the click classifier,
// predicts the events that each sample transfer should cause and compares them
// with the event transfers in order.
module click_event_checker
    import bcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bcc_in_if                     i_sample_ch,
    bcc_out_if                    i_event_ch,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int BUTTONS = 1 << BTN_W;

    typedef struct packed {
        logic [BTN_W-1:0]  button;
        logic [CODE_W-1:0] code;
    } t_click_event;

    t_click_event expected_events [$];
    int           fail_total;

    // Shadow copy of the register file.
    logic [MS_CFG_W-1:0] settle_span;
    logic [MS_CFG_W-1:0] long_ms;
    logic [MS_CFG_W-1:0] window_ms;
    logic [CODE_W-1:0]   short_code;
    logic [CODE_W-1:0]   double_code;
    logic [CODE_W-1:0]   long_code;
    logic [MASK_W-1:0]   enabled;

    // Per-button tracking state.
    logic               raw_seen    [BUTTONS];
    logic               debounced   [BUTTONS];
    logic               hold_flagged [BUTTONS];
    logic [CLICK_W-1:0] clicks      [BUTTONS];
    logic [NOW_W-1:0]   change_at   [BUTTONS];
    logic [NOW_W-1:0]   pressed_at  [BUTTONS];
    logic [NOW_W-1:0]   released_at [BUTTONS];

    // Runs one poll sample through the button tracker and queues any event it raises.
    task automatic classify_sample(input logic [BTN_W-1:0] btn, input logic lvl,
                                   input logic [NOW_W-1:0] now);
        logic [CODE_W-1:0] code;
        logic [NOW_W-1:0]  since_change;
        logic [NOW_W-1:0]  since_press;
        logic [NOW_W-1:0]  since_release;
        code = '0;
        if (enabled[btn]) begin
            if (lvl != raw_seen[btn]) begin
                raw_seen[btn]  = lvl;
                change_at[btn] = now;
            end

            // Debounce: the raw level becomes stable once it has held long enough.
            since_change = now - change_at[btn];
            if (debounced[btn] != lvl && since_change >= NOW_W'(settle_span)) begin
                debounced[btn] = lvl;
                if (lvl) begin
                    pressed_at[btn]   = now;
                    hold_flagged[btn] = 1'b0;
                end else if (!hold_flagged[btn]) begin
                    if (clicks[btn] < CLICK_MAX) begin
                        clicks[btn] = clicks[btn] + CLICK_W'(1);
                    end
                    released_at[btn] = now;
                end
            end

            // A long hold wins; otherwise pending clicks resolve after a quiet window.
            since_press   = now - pressed_at[btn];
            since_release = now - released_at[btn];
            if (debounced[btn] && !hold_flagged[btn] && since_press >= NOW_W'(long_ms)) begin
                hold_flagged[btn] = 1'b1;
                clicks[btn]       = '0;
                code              = long_code;
            end else if (!debounced[btn] && clicks[btn] != '0 &&
                         since_release >= NOW_W'(window_ms)) begin
                code        = (clicks[btn] >= DOUBLE_CLICKS) ? double_code : short_code;
                clicks[btn] = '0;
            end

            if (code != '0) begin
                expected_events.push_back('{button: btn, code: code});
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_click_event want;
        if (!i_rst_n) begin
            settle_span = DEBOUNCE_RST;
            long_ms     = LONG_RST;
            window_ms   = WINDOW_RST;
            short_code  = '0;
            double_code = '0;
            long_code   = '0;
            enabled     = '0;
            for (int b = 0; b < BUTTONS; b++) begin
                raw_seen[b]     = 1'b0;
                debounced[b]    = 1'b0;
                hold_flagged[b] = 1'b0;
                clicks[b]       = '0;
                change_at[b]    = '0;
                pressed_at[b]   = '0;
                released_at[b]  = '0;
            end
            expected_events.delete();
        end else begin
            // Register writes complete on the access cycle.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[APB_ADDR_W-1:2]))
                    REG_DEBOUNCE_TIME:   settle_span = i_pwdata[MS_CFG_W-1:0];
                    REG_LONG_PRESS_TIME: long_ms     = i_pwdata[MS_CFG_W-1:0];
                    REG_DOUBLE_WINDOW:   window_ms   = i_pwdata[MS_CFG_W-1:0];
                    REG_SHORT_ACTION:    short_code  = i_pwdata[CODE_W-1:0];
                    REG_DOUBLE_ACTION:   double_code = i_pwdata[CODE_W-1:0];
                    REG_LONG_ACTION:     long_code   = i_pwdata[CODE_W-1:0];
                    REG_ENABLE_MASK:     enabled     = i_pwdata[MASK_W-1:0];
                    default: ;
                endcase
            end

            // Each event transfer is matched against the oldest prediction.
            if (i_event_ch.valid && i_event_ch.ready) begin
                if (expected_events.size() == 0) begin
                    $error("action_code: unexpected event, button %0d code 0x%02h",
                           i_event_ch.event_button, i_event_ch.action_code);
                    fail_total++;
                end else begin
                    want = expected_events.pop_front();
                    if (i_event_ch.event_button !== want.button) begin
                        $error("event_button: expected %0d, actual %0d",
                               want.button, i_event_ch.event_button);
                        fail_total++;
                    end
                    if (i_event_ch.action_code !== want.code) begin
                        $error("action_code: expected 0x%02h, actual 0x%02h",
                               want.code, i_event_ch.action_code);
                        fail_total++;
                    end
                end
            end

            if (i_sample_ch.valid && i_sample_ch.ready) begin
                classify_sample(i_sample_ch.button_index, i_sample_ch.raw_level,
                                i_sample_ch.now_ms);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_events.size();
    end

endmodule

@@ dv/button_click_classifier_unit_tb.sv @@
`timescale 1ns / 100ps

module button_click_classifier_unit_tb;
    import bcc_pkg::*;

    // Index past the end of the register map; writes to it must be dropped.
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
    // Margin waited after the last predicted event has left the block.
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_SAMPLES = 305;

    typedef enum {
        GEST_NOISE,
        GEST_SHORT,
        GEST_DOUBLE,
        GEST_TRIPLE,
        GEST_LONG
    } t_gesture;

    typedef struct {
        logic [MS_CFG_W-1:0] debounce;
        logic [MS_CFG_W-1:0] long_press;
        logic [MS_CFG_W-1:0] window;
        logic [CODE_W-1:0]   short_code;
        logic [CODE_W-1:0]   double_code;
        logic [CODE_W-1:0]   long_code;
        logic [MASK_W-1:0]   mask;
    } t_settings;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int send_pct;
    int stall_pct;
    int sent_count;
    logic [NOW_W-1:0] stamp;
    t_settings cur;

    bcc_in_if  sample_ch ();
    bcc_out_if event_ch ();

    button_click_classifier_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_ch),
        .o_out   (event_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    click_event_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample_ch  (sample_ch),
        .i_event_ch   (event_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns clock.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Event receiver stalls at random.
    always @(posedge i_clk) begin
        event_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hard stop in case the block hangs.
    initial begin
        #2000000;
        $display("[button_click_classifier_unit] ERROR");
        $finish;
    end

    // One register write; psel stays high so writes can follow back to back.
    task automatic apb_access(input logic [REG_IDX_W-1:0] idx,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    // Loads the whole register file, optionally also the unused index; upper data bits carry junk that must be dropped.
    task automatic write_settings(input t_settings s, input bit poke_unused);
        apb_access(REG_DEBOUNCE_TIME,   {16'($urandom()), s.debounce});
        apb_access(REG_LONG_PRESS_TIME, {16'($urandom()), s.long_press});
        apb_access(REG_DOUBLE_WINDOW,   {16'($urandom()), s.window});
        apb_access(REG_SHORT_ACTION,    {24'($urandom()), s.short_code});
        apb_access(REG_DOUBLE_ACTION,   {24'($urandom()), s.double_code});
        apb_access(REG_LONG_ACTION,     {24'($urandom()), s.long_code});
        apb_access(REG_ENABLE_MASK,     {24'($urandom()), s.mask});
        if (poke_unused) begin
            apb_access(REG_UNUSED, '1);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        cur = s;
    endtask

    // Offers one sample after a random gap and returns on its transfer edge.
    task automatic send_sample(input logic [BTN_W-1:0] btn, input logic lvl,
                               input logic [NOW_W-1:0] now);
        while ($urandom_range(99) < send_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.button_index <= btn;
        sample_ch.raw_level    <= lvl;
        sample_ch.now_ms       <= now;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        sent_count++;
    endtask

    // Advances the time stamp and polls one button, sometimes another one too.
    task automatic poll(input logic [BTN_W-1:0] btn, input logic lvl, input int unsigned dt);
        stamp += dt;
        send_sample(btn, lvl, stamp);
        if ($urandom_range(99) < 15) begin
            send_sample(BTN_W'($urandom()), 1'($urandom()), stamp);
        end
    endtask

    // Holds a level for at least span ms, with contact bounce at the start half the time.
    task automatic hold(input logic [BTN_W-1:0] btn, input logic lvl, input int unsigned span);
        int unsigned held;
        int unsigned dt;
        int unsigned step;
        if ($urandom_range(1) == 1) begin
            repeat ($urandom_range(1, 3)) begin
                poll(btn, !lvl, $urandom_range(0, 2));
                poll(btn, lvl, $urandom_range(0, 2));
            end
        end
        step = span / 3 + 1;
        held = 0;
        do begin
            dt = $urandom_range(1, step);
            poll(btn, lvl, dt);
            held += dt;
        end while (held < span);
    endtask

    // Plays one user gesture on a button, timed against the current settings.
    task automatic gesture(input logic [BTN_W-1:0] btn, input t_gesture g);
        int unsigned deb;
        int unsigned lng;
        int unsigned win;
        int unsigned presses;
        deb = cur.debounce;
        lng = cur.long_press;
        win = cur.window;
        case (g)
            GEST_NOISE: begin
                repeat ($urandom_range(2, 8)) begin
                    poll(btn, 1'($urandom()), $urandom_range(0, deb + 5));
                end
            end
            GEST_LONG: begin
                hold(btn, 1'b1, deb + lng + $urandom_range(0, 20));
                hold(btn, 1'b0, deb + win + $urandom_range(0, 20));
            end
            default: begin
                presses = (g == GEST_SHORT) ? 1 : (g == GEST_DOUBLE) ? 2 : $urandom_range(3, 5);
                for (int unsigned p = 0; p < presses; p++) begin
                    hold(btn, 1'b1, deb + $urandom_range(0, lng / 2));
                    if (p == presses - 1) begin
                        hold(btn, 1'b0, deb + win + $urandom_range(0, 20));
                    end else begin
                        hold(btn, 1'b0, deb + $urandom_range(0, win / 2));
                    end
                end
            end
        endcase
    endtask

    // Waits until every predicted event has left the block, then a little longer.
    task automatic drain_events();
        sample_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_settings s;
        int        target;
        int        pick;
        t_gesture  g;

        sample_ch.valid        <= 1'b0;
        sample_ch.button_index <= '0;
        sample_ch.raw_level    <= 1'b0;
        sample_ch.now_ms       <= '0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        i_rst_n                <= 1'b0;
        send_pct   = 30;
        stall_pct  = 88;
        sent_count = 0;
        stamp      = '0;
        cur = '{debounce: DEBOUNCE_RST, long_press: LONG_RST, window: WINDOW_RST,
                short_code: '0, double_code: '0, long_code: '0, mask: '0};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out of reset every button is disabled, so these are ignored.
        send_sample(3'd0, 1'b1, 32'd0);
        send_sample(3'd7, 1'b0, 32'hFFFF_FFFF);
        drain_events();

        // Zero times: the press stabilizes and the long action fires on one sample.
        // The long press is not counted as a click on release, across a time wrap.
        write_settings('{debounce: 16'd0, long_press: 16'd0, window: 16'd0,
                         short_code: 8'h01, double_code: 8'hFF, long_code: 8'h80,
                         mask: 8'hFF}, 1'b1);
        send_sample(3'd7, 1'b1, 32'hFFFF_FFFF);
        send_sample(3'd7, 1'b0, 32'd0);
        send_sample(3'd0, 1'b0, 32'd5);
        drain_events();

        // Disabled button, single click, silent long press and click saturation.
        write_settings('{debounce: 16'd0, long_press: 16'd10, window: 16'd5,
                         short_code: 8'h5A, double_code: 8'hFF, long_code: 8'h00,
                         mask: 8'h7F}, 1'b0);
        send_sample(3'd7, 1'b1, 32'd100);
        send_sample(3'd1, 1'b1, 32'd100);
        send_sample(3'd1, 1'b0, 32'd101);
        send_sample(3'd1, 1'b0, 32'd106);
        send_sample(3'd2, 1'b1, 32'd200);
        send_sample(3'd2, 1'b1, 32'd210);
        send_sample(3'd2, 1'b0, 32'd211);
        for (int k = 0; k < 4; k++) begin
            send_sample(3'd3, 1'b1, 32'(300 + 2 * k));
            send_sample(3'd3, 1'b0, 32'(301 + 2 * k));
        end
        send_sample(3'd3, 1'b0, 32'd312);
        drain_events();

        // Random gestures over several settings and three idling regimes.
        for (int phase = 0; phase < 6; phase++) begin
            send_pct  = (phase < 2) ? 30 : (phase < 4) ? 88 : 0;
            stall_pct = (phase < 2) ? 88 : (phase < 4) ? 30 : 0;
            case (phase)
                0: s = '{debounce: 16'd5, long_press: 16'd60, window: 16'd40,
                         short_code: 8'h11, double_code: 8'h22, long_code: 8'h33,
                         mask: 8'hFF};
                1: s = '{debounce: 16'hFFFF, long_press: 16'hFFFF, window: 16'hFFFF,
                         short_code: 8'h01, double_code: 8'hFE, long_code: 8'h00,
                         mask: 8'h5A};
                2: s = '{debounce: 16'd0, long_press: 16'd0, window: 16'd0,
                         short_code: 8'hFF, double_code: 8'h01, long_code: 8'h80,
                         mask: 8'hA5};
                5: s = '{debounce: 16'd3, long_press: 16'd50, window: 16'd30,
                         short_code: 8'h00, double_code: 8'hC3, long_code: 8'h3C,
                         mask: 8'($urandom())};
                default: s = '{debounce: 16'($urandom_range(0, 30)),
                               long_press: 16'($urandom_range(40, 200)),
                               window: 16'($urandom_range(20, 100)),
                               short_code: 8'($urandom()), double_code: 8'($urandom()),
                               long_code: 8'($urandom()), mask: 8'($urandom())};
            endcase
            drain_events();
            write_settings(s, 1'b0);
            stamp  = $urandom();
            target = sent_count + PHASE_SAMPLES;
            while (sent_count < target) begin
                pick = $urandom_range(99);
                if (pick < 15)      g = GEST_NOISE;
                else if (pick < 40) g = GEST_SHORT;
                else if (pick < 65) g = GEST_DOUBLE;
                else if (pick < 80) g = GEST_TRIPLE;
                else                g = GEST_LONG;
                gesture(BTN_W'($urandom()), g);
            end
        end

        drain_events();
        if (fail_count == 0 && pending == 0) begin
            $display("[button_click_classifier_unit] OK");
        end else begin
            $display("[button_click_classifier_unit] ERROR");
        end
        $finish;
    end

endmodule
